// File: design/rar_pkg.sv
package rar_pkg;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_COMB,
        S_GCD,
        S_DIV,
        S_DONE
    } t_state;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } t_op;

    // Load and shift strobes shared by a group of serial lanes.
    typedef struct packed {
        logic load;
        logic step;
    } t_lane_ctl;

    localparam int NUM_OUT_W = 33;
    localparam int DEN_OUT_W = 32;

endpackage

// File: design/rar_mul.sv
module rar_mul #(
    parameter int WIDTH = 16
) (
    input  logic                  i_clk,
    input  rar_pkg::t_lane_ctl    i_ctl,
    input  logic [WIDTH-1:0]      i_mcand,
    input  logic [WIDTH-1:0]      i_mplr,
    output logic [2*WIDTH-1:0]    o_prod
);

    logic [WIDTH-1:0]   r_mcand;
    logic [2*WIDTH-1:0] r_prod;
    logic [WIDTH:0]     n_upper;

    // One multiplier bit per cycle while step is set: the low half shifts the multiplier out
    // while the partial sum grows into the high half.
    always_comb begin
        n_upper = {1'b0, r_prod[2*WIDTH-1:WIDTH]}
                + (r_prod[0] ? {1'b0, r_mcand} : {(WIDTH+1){1'b0}});
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_mcand <= i_mcand;
            r_prod  <= {{WIDTH{1'b0}}, i_mplr};
        end else if (i_ctl.step) begin
            r_prod  <= {n_upper, r_prod[WIDTH-1:1]};
        end
    end

    assign o_prod = r_prod;

endmodule

// File: design/rar_div.sv
module rar_div #(
    parameter int WIDTH = 32
) (
    input  logic                  i_clk,
    input  rar_pkg::t_lane_ctl    i_ctl,
    input  logic [WIDTH-1:0]      i_dividend,
    input  logic [WIDTH-1:0]      i_divisor,
    output logic [WIDTH-1:0]      o_quot
);

    logic [WIDTH-1:0] r_quot;
    logic [WIDTH-1:0] r_rem;
    logic [WIDTH:0]   trial;
    logic [WIDTH:0]   diff;
    logic             fits;

    // Restoring division, one quotient bit per cycle while step is set. The remainder stays
    // below the divisor, so it fits in WIDTH bits between steps.
    always_comb begin
        trial = {r_rem, r_quot[WIDTH-1]};
        diff  = trial - {1'b0, i_divisor};
        fits  = (trial >= {1'b0, i_divisor});
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_quot <= i_dividend;
            r_rem  <= '0;
        end else if (i_ctl.step) begin
            r_quot <= {r_quot[WIDTH-2:0], fits};
            r_rem  <= fits ? diff[WIDTH-1:0] : trial[WIDTH-1:0];
        end
    end

    assign o_quot = r_quot;

endmodule

// File: design/rational_arith_reduce.sv
// Channel   Direction  Handshake            Payload
// input     in         i_valid / o_ready    i_op, i_a_num, i_a_den, i_b_num, i_b_den
// result    out        o_valid / i_ready    o_res_num, o_res_den, o_den_zero
//
// One item at a time. An item passes through the serial multiplier lanes, a
// combine step, binary gcd steps and the restoring divider lanes; a zero
// numerator or denominator skips the gcd and the division.
// Reset is synchronous and active low and clears the control state only.
// A waiting result sits in the output register while the next item is taken;
// a finished item waits in its last state until that register is free.
module rational_arith_reduce #(
    parameter int OPERAND_WIDTH = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [1:0]                          i_op,
    input  logic signed [OPERAND_WIDTH-1:0]     i_a_num,
    input  logic signed [OPERAND_WIDTH-1:0]     i_a_den,
    input  logic signed [OPERAND_WIDTH-1:0]     i_b_num,
    input  logic signed [OPERAND_WIDTH-1:0]     i_b_den,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic signed [rar_pkg::NUM_OUT_W-1:0] o_res_num,
    output logic signed [rar_pkg::DEN_OUT_W-1:0] o_res_den,
    output logic                                o_den_zero
);

    localparam int W  = OPERAND_WIDTH;
    localparam int MW = 2 * OPERAND_WIDTH;
    localparam int CW = $clog2(MW);
    localparam int XW = (MW + 1 > rar_pkg::NUM_OUT_W) ? MW + 1 : rar_pkg::NUM_OUT_W;

    rar_pkg::t_state    r_state, n_state;
    rar_pkg::t_op       r_op;
    rar_pkg::t_lane_ctl ctl_mul, ctl_div;

    logic [CW-1:0] r_cnt;
    logic [2:0]    r_sgn;
    logic [MW-1:0] r_n, r_d, r_u, r_v;
    logic          r_n_neg, r_d_neg, r_den_zero, r_reduced;

    logic                               r_out_valid, r_out_dz;
    logic [rar_pkg::NUM_OUT_W-1:0]      r_res_num;
    logic [rar_pkg::DEN_OUT_W-1:0]      r_res_den;

    logic          an_neg, ad_neg, bn_neg, bd_neg;
    logic [W-1:0]  an_mag, ad_mag, bn_mag, bd_mag;
    logic [W-1:0]  l0_mplr, l2_mplr;
    logic [2:0]    in_sgn;
    logic          in_mul, in_div;

    logic [MW-1:0] prod0, prod1, prod2, quot_n, quot_d;
    logic          p_neg, q_neg, d_neg;
    logic [MW-1:0] add_mag, cmb_n;
    logic          add_neg, cmb_n_neg;
    logic          gcd_end, out_free;
    logic [MW-1:0] fin_n, fin_d, gcd_val;
    logic [XW-1:0] ext_n, ext_d, sval_n, sval_d;

    // Sign and magnitude of the operand fields.
    always_comb begin
        an_neg = i_a_num[W-1];
        ad_neg = i_a_den[W-1];
        bn_neg = i_b_num[W-1];
        bd_neg = i_b_den[W-1];
        an_mag = an_neg ? (~i_a_num + 1'b1) : i_a_num;
        ad_mag = ad_neg ? (~i_a_den + 1'b1) : i_a_den;
        bn_mag = bn_neg ? (~i_b_num + 1'b1) : i_b_num;
        bd_mag = bd_neg ? (~i_b_den + 1'b1) : i_b_den;
        in_mul = (rar_pkg::t_op'(i_op) == rar_pkg::OP_MUL);
        in_div = (rar_pkg::t_op'(i_op) == rar_pkg::OP_DIV);
        // Lane 0 gives the numerator product, or the first cross product for add and
        // subtract, lane 1 the second cross product for add and subtract, lane 2 the denominator product.
        l0_mplr   = in_mul ? bn_mag : bd_mag;
        l2_mplr   = in_div ? bn_mag : bd_mag;
        in_sgn[0] = an_neg ^ (in_mul ? bn_neg : bd_neg);
        in_sgn[1] = bn_neg ^ ad_neg;
        in_sgn[2] = ad_neg ^ (in_div ? bn_neg : bd_neg);
    end

    rar_mul #(.WIDTH(W)) u_mul0 (
        .i_clk(i_clk), .i_ctl(ctl_mul), .i_mcand(an_mag), .i_mplr(l0_mplr), .o_prod(prod0)
    );
    rar_mul #(.WIDTH(W)) u_mul1 (
        .i_clk(i_clk), .i_ctl(ctl_mul), .i_mcand(bn_mag), .i_mplr(ad_mag), .o_prod(prod1)
    );
    rar_mul #(.WIDTH(W)) u_mul2 (
        .i_clk(i_clk), .i_ctl(ctl_mul), .i_mcand(ad_mag), .i_mplr(l2_mplr), .o_prod(prod2)
    );

    // Combine the products into a signed-magnitude numerator and denominator.
    always_comb begin
        p_neg = r_sgn[0] && (prod0 != '0);
        q_neg = (r_sgn[1] ^ (r_op == rar_pkg::OP_SUB)) && (prod1 != '0);
        d_neg = r_sgn[2] && (prod2 != '0);
        if (p_neg == q_neg) begin
            add_mag = prod0 + prod1;
            add_neg = p_neg;
        end else if (prod0 >= prod1) begin
            add_mag = prod0 - prod1;
            add_neg = p_neg;
        end else begin
            add_mag = prod1 - prod0;
            add_neg = q_neg;
        end
        if (r_op == rar_pkg::OP_ADD || r_op == rar_pkg::OP_SUB) begin
            cmb_n     = add_mag;
            cmb_n_neg = add_neg && (add_mag != '0);
        end else begin
            cmb_n     = prod0;
            cmb_n_neg = p_neg;
        end
    end

    assign gcd_end  = (r_u == '0) || (r_v == '0);
    assign gcd_val  = r_u | r_v;
    assign out_free = !r_out_valid || i_ready;

    rar_div #(.WIDTH(MW)) u_div_n (
        .i_clk(i_clk), .i_ctl(ctl_div), .i_dividend(r_n), .i_divisor(gcd_val), .o_quot(quot_n)
    );
    rar_div #(.WIDTH(MW)) u_div_d (
        .i_clk(i_clk), .i_ctl(ctl_div), .i_dividend(r_d), .i_divisor(gcd_val), .o_quot(quot_d)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            rar_pkg::S_IDLE: if (i_valid) n_state = rar_pkg::S_MUL;
            rar_pkg::S_MUL:  if (r_cnt == '0) n_state = rar_pkg::S_COMB;
            rar_pkg::S_COMB: begin
                if (prod2 == '0 || cmb_n == '0) n_state = rar_pkg::S_DONE;
                else n_state = rar_pkg::S_GCD;
            end
            rar_pkg::S_GCD:  if (gcd_end) n_state = rar_pkg::S_DIV;
            rar_pkg::S_DIV:  if (r_cnt == '0) n_state = rar_pkg::S_DONE;
            rar_pkg::S_DONE: if (out_free) n_state = rar_pkg::S_IDLE;
            default:         n_state = rar_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_ready      = (r_state == rar_pkg::S_IDLE);
        ctl_mul.load = (r_state == rar_pkg::S_IDLE) && i_valid;
        ctl_mul.step = (r_state == rar_pkg::S_MUL);
        ctl_div.load = (r_state == rar_pkg::S_GCD) && gcd_end;
        ctl_div.step = (r_state == rar_pkg::S_DIV);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rar_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctl_mul.load) begin
            r_cnt <= CW'(W - 1);
            r_op  <= rar_pkg::t_op'(i_op);
            r_sgn <= in_sgn;
        end else if (ctl_div.load) begin
            r_cnt <= CW'(MW - 1);
        end else if (ctl_mul.step || ctl_div.step) begin
            r_cnt <= r_cnt - 1'b1;
        end

        if (r_state == rar_pkg::S_COMB) begin
            r_n        <= cmb_n;
            r_n_neg    <= cmb_n_neg;
            r_d        <= prod2;
            r_d_neg    <= d_neg;
            r_u        <= cmb_n;
            r_v        <= prod2;
            r_den_zero <= (prod2 == '0);
            r_reduced  <= (prod2 != '0) && (cmb_n != '0);
        end else if (r_state == rar_pkg::S_GCD && !gcd_end) begin
            priority if (!r_u[0] && !r_v[0]) begin
                // A common factor of two comes off the operands themselves
                // too, so the dividers only see the odd part of the gcd.
                r_u <= r_u >> 1;
                r_v <= r_v >> 1;
                r_n <= r_n >> 1;
                r_d <= r_d >> 1;
            end else if (!r_u[0]) begin
                r_u <= r_u >> 1;
            end else if (!r_v[0]) begin
                r_v <= r_v >> 1;
            end else if (r_u >= r_v) begin
                r_u <= (r_u - r_v) >> 1;
            end else begin
                r_v <= (r_v - r_u) >> 1;
            end
        end
    end

    always_comb begin
        fin_n  = r_reduced ? quot_n : r_n;
        fin_d  = r_reduced ? quot_d : r_d;
        ext_n  = {{(XW-MW){1'b0}}, fin_n};
        ext_d  = {{(XW-MW){1'b0}}, fin_d};
        sval_n = r_n_neg ? (~ext_n + 1'b1) : ext_n;
        sval_d = r_d_neg ? (~ext_d + 1'b1) : ext_d;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == rar_pkg::S_DONE && out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == rar_pkg::S_DONE && out_free) begin
            r_res_num <= sval_n[rar_pkg::NUM_OUT_W-1:0];
            r_res_den <= sval_d[rar_pkg::DEN_OUT_W-1:0];
            r_out_dz  <= r_den_zero;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_res_num  = r_res_num;
    assign o_res_den  = r_res_den;
    assign o_den_zero = r_out_dz;

endmodule

// File: design/rar_checker.sv
module rar_assertions (
    input logic                                 i_clk,
    input logic                                 i_rst_n,
    input logic                                 i_valid,
    input logic                                 o_ready,
    input logic                                 o_valid,
    input logic                                 i_ready,
    input logic signed [rar_pkg::NUM_OUT_W-1:0] o_res_num,
    input logic signed [rar_pkg::DEN_OUT_W-1:0] o_res_den,
    input logic                                 o_den_zero
);

    // A result that is not taken stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid)
        else $error("result withdrawn before it was taken");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> $stable(o_res_num) && $stable(o_res_den)
                                && $stable(o_den_zero))
        else $error("stalled result changed");

    // A zero denominator is reported with a zero denominator field.
    a_dz_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_den_zero |-> o_res_den == '0)
        else $error("den_zero set with nonzero denominator");

    // The block works on one item at a time.
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("input taken again while an item is in progress");

endmodule

bind rational_arith_reduce rar_assertions u_rar_assertions (.*);

// File: verif/rar_checker.sv
module rar_checker #(
    parameter int OPW = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    input  logic                                 i_in_ready,
    input  logic [1:0]                           i_op,
    input  logic signed [OPW-1:0]                i_a_num,
    input  logic signed [OPW-1:0]                i_a_den,
    input  logic signed [OPW-1:0]                i_b_num,
    input  logic signed [OPW-1:0]                i_b_den,
    input  logic                                 i_res_valid,
    input  logic                                 i_res_ready,
    input  logic signed [rar_pkg::NUM_OUT_W-1:0] i_res_num,
    input  logic signed [rar_pkg::DEN_OUT_W-1:0] i_res_den,
    input  logic                                 i_den_zero,
    output int                                   o_fail_cnt,
    output int                                   o_pending_cnt
);

    typedef struct packed {
        rar_pkg::t_op                         op;
        logic signed [OPW-1:0]                a_num;
        logic signed [OPW-1:0]                a_den;
        logic signed [OPW-1:0]                b_num;
        logic signed [OPW-1:0]                b_den;
        logic signed [rar_pkg::NUM_OUT_W-1:0] num;
        logic signed [rar_pkg::DEN_OUT_W-1:0] den;
        logic                                 den_zero;
    } t_frac_entry;

    t_frac_entry reduced_fracs[$];
    int          mismatches = 0;

    assign o_fail_cnt = mismatches;

    // Exact products in 64 bits, then, if both are nonzero, both parts divided by the gcd of
    // their magnitudes. Signs are left on whichever part they land.
    function automatic t_frac_entry reduce_fraction(input rar_pkg::t_op op,
                                                    input logic signed [OPW-1:0] an,
                                                    input logic signed [OPW-1:0] ad,
                                                    input logic signed [OPW-1:0] bn,
                                                    input logic signed [OPW-1:0] bd);
        longint      n;
        longint      d;
        longint      x;
        longint      y;
        longint      t;
        t_frac_entry e;
        case (op)
            rar_pkg::OP_ADD: begin
                n = longint'(an) * longint'(bd) + longint'(bn) * longint'(ad);
                d = longint'(ad) * longint'(bd);
            end
            rar_pkg::OP_SUB: begin
                n = longint'(an) * longint'(bd) - longint'(bn) * longint'(ad);
                d = longint'(ad) * longint'(bd);
            end
            rar_pkg::OP_MUL: begin
                n = longint'(an) * longint'(bn);
                d = longint'(ad) * longint'(bd);
            end
            default: begin
                n = longint'(an) * longint'(bd);
                d = longint'(ad) * longint'(bn);
            end
        endcase
        e.op = op;
        e.a_num = an;
        e.a_den = ad;
        e.b_num = bn;
        e.b_den = bd;
        e.den_zero = (d == 0);
        if (d != 0 && n != 0) begin
            x = (n < 0) ? -n : n;
            y = (d < 0) ? -d : d;
            while (y != 0) begin
                t = x % y;
                x = y;
                y = t;
            end
            n = n / x;
            d = d / x;
        end
        e.num = n[rar_pkg::NUM_OUT_W-1:0];
        e.den = d[rar_pkg::DEN_OUT_W-1:0];
        return e;
    endfunction

    always @(posedge i_clk) begin : monitor
        t_frac_entry want;
        if (i_rst_n) begin
            if (i_res_valid && i_res_ready) begin
                if (reduced_fracs.size() == 0) begin
                    if (mismatches < 10) begin
                        $display("unexpected result item: num %0d den %0d den_zero %0b",
                                 i_res_num, i_res_den, i_den_zero);
                    end
                    mismatches = mismatches + 1;
                end else begin
                    want = reduced_fracs.pop_front();
                    if (i_res_num !== want.num || i_res_den !== want.den ||
                        i_den_zero !== want.den_zero) begin
                        if (mismatches < 10) begin
                            $display({"mismatch %s %0d/%0d, %0d/%0d: ",
                                      "expected %0d/%0d dz %0b, got %0d/%0d dz %0b"},
                                     want.op.name(), want.a_num, want.a_den, want.b_num,
                                     want.b_den, want.num, want.den, want.den_zero,
                                     i_res_num, i_res_den, i_den_zero);
                        end
                        mismatches = mismatches + 1;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                reduced_fracs.push_back(reduce_fraction(rar_pkg::t_op'(i_op), i_a_num,
                                                        i_a_den, i_b_num, i_b_den));
            end
        end
        o_pending_cnt <= reduced_fracs.size();
    end

endmodule

// File: verif/tb_top.sv
module tb_top;

    localparam int OPW            = 16;
    localparam int RANDOM_ITEMS   = 650;
    localparam int RX_HOLD_CYCLES = 800;
    localparam int DRAIN_CYCLES   = 200;
    localparam int LIMIT_CYCLES   = 800000;

    logic                                 i_clk = 1'b0;
    logic                                 i_rst_n;
    logic                                 i_valid;
    logic                                 o_ready;
    logic [1:0]                           i_op;
    logic signed [OPW-1:0]                i_a_num;
    logic signed [OPW-1:0]                i_a_den;
    logic signed [OPW-1:0]                i_b_num;
    logic signed [OPW-1:0]                i_b_den;
    logic                                 o_valid;
    logic                                 i_ready;
    logic signed [rar_pkg::NUM_OUT_W-1:0] o_res_num;
    logic signed [rar_pkg::DEN_OUT_W-1:0] o_res_den;
    logic                                 o_den_zero;

    int fail_cnt;
    int pending_cnt;
    int cycle_cnt = 0;
    int rx_hold_asks = 0;

    rational_arith_reduce #(
        .OPERAND_WIDTH(OPW)
    ) uut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_ready(o_ready),
        .i_op(i_op),
        .i_a_num(i_a_num),
        .i_a_den(i_a_den),
        .i_b_num(i_b_num),
        .i_b_den(i_b_den),
        .o_valid(o_valid),
        .i_ready(i_ready),
        .o_res_num(o_res_num),
        .o_res_den(o_res_den),
        .o_den_zero(o_den_zero)
    );

    rar_checker #(
        .OPW(OPW)
    ) u_checker (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_valid),
        .i_in_ready(o_ready),
        .i_op(i_op),
        .i_a_num(i_a_num),
        .i_a_den(i_a_den),
        .i_b_num(i_b_num),
        .i_b_den(i_b_den),
        .i_res_valid(o_valid),
        .i_res_ready(i_ready),
        .i_res_num(o_res_num),
        .i_res_den(o_res_den),
        .i_den_zero(o_den_zero),
        .o_fail_cnt(fail_cnt),
        .o_pending_cnt(pending_cnt)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
    end

    initial begin
        wait (cycle_cnt >= LIMIT_CYCLES);
        $display("rational_arith_reduce test failed");
        $finish;
    end

    // Offer one item and hold it until the block takes it.
    task automatic send_item(input rar_pkg::t_op op,
                             input logic signed [OPW-1:0] an,
                             input logic signed [OPW-1:0] ad,
                             input logic signed [OPW-1:0] bn,
                             input logic signed [OPW-1:0] bd);
        i_valid <= 1'b1;
        i_op <= op;
        i_a_num <= an;
        i_a_den <= ad;
        i_b_num <= bn;
        i_b_den <= bd;
        do @(posedge i_clk); while (!o_ready);
    endtask

    task automatic idle_for(input int cycles);
        if (cycles > 0) begin
            i_valid <= 1'b0;
            repeat (cycles) @(posedge i_clk);
        end
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending_cnt != 0);
    endtask

    // Mix of zeros, extremes, small values and values rich in repeated factors.
    function automatic logic signed [OPW-1:0] rand_operand();
        logic [31:0]           raw;
        logic signed [OPW-1:0] v;
        int                    base;
        raw = $urandom();
        case ($urandom_range(0, 15))
            0: v = '0;
            1: begin
                case ($urandom_range(0, 3))
                    0: v = OPW'(-32768);
                    1: v = OPW'(32767);
                    2: v = OPW'(1);
                    default: v = OPW'(-1);
                endcase
            end
            2, 3, 4, 5, 6: v = OPW'(int'($urandom_range(0, 48)) - 24);
            7, 8: begin
                case ($urandom_range(0, 5))
                    0: base = 1;
                    1: base = 3;
                    2: base = 9;
                    3: base = 5;
                    4: base = 15;
                    default: base = 7;
                endcase
                v = OPW'(base << $urandom_range(0, 10));
                if (raw[31]) v = -v;
            end
            default: v = raw[OPW-1:0];
        endcase
        return v;
    endfunction

    // Receiver: changes between stall patterns, and holds off for a long
    // stretch whenever the stimulus asks for it.
    initial begin : receiver
        int rx_hold_done;
        int mode;
        int mode_left;
        int phase;
        int period;
        rx_hold_done = 0;
        mode = 0;
        mode_left = 0;
        phase = 0;
        period = 2;
        i_ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (rx_hold_asks != rx_hold_done) begin
                i_ready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(posedge i_clk);
                rx_hold_done = rx_hold_done + 1;
            end else begin
                if (mode_left == 0) begin
                    mode = $urandom_range(0, 3);
                    mode_left = $urandom_range(20, 300);
                    period = $urandom_range(2, 9);
                end
                mode_left = mode_left - 1;
                phase = phase + 1;
                case (mode)
                    0: i_ready <= 1'b1;
                    1: i_ready <= 1'($urandom_range(0, 1));
                    2: i_ready <= ((phase % period) == 0);
                    default: i_ready <= ($urandom_range(0, 7) == 0);
                endcase
            end
        end
    end

    initial begin : stimulus
        int sent;
        int burst_left;
        int gap;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_op = rar_pkg::OP_ADD;
        i_a_num = '0;
        i_a_den = '0;
        i_b_num = '0;
        i_b_den = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_item(rar_pkg::OP_ADD, 1, 2, 1, 3);
        idle_for($urandom_range(0, 3));
        send_item(rar_pkg::OP_SUB, 1, 2, 1, 2);
        send_item(rar_pkg::OP_MUL, 8, 12, 9, 6);
        send_item(rar_pkg::OP_DIV, 4, 9, 2, 3);
        idle_for($urandom_range(0, 3));
        send_item(rar_pkg::OP_ADD, 1, 0, 1, 5);
        send_item(rar_pkg::OP_DIV, 3, 4, 0, 7);
        send_item(rar_pkg::OP_MUL, -32768, -32768, -32768, -32768);
        send_item(rar_pkg::OP_ADD, -32768, -32768, -32768, 0);
        idle_for($urandom_range(0, 3));
        send_item(rar_pkg::OP_SUB, 32767, -32768, -32768, 32767);
        send_item(rar_pkg::OP_MUL, 32767, 32767, -1, 1);
        send_item(rar_pkg::OP_DIV, -1, -1, -1, -1);
        send_item(rar_pkg::OP_ADD, 0, 0, 0, 0);
        idle_for($urandom_range(0, 3));
        send_item(rar_pkg::OP_DIV, 5, -3, 7, 2);
        send_item(rar_pkg::OP_SUB, 32767, 1, -32768, 1);
        send_item(rar_pkg::OP_MUL, 0, -5, 3, 7);
        send_item(rar_pkg::OP_ADD, -7, 3, 7, 3);
        send_item(rar_pkg::OP_DIV, 32767, -32768, -32768, 32767);
        send_item(rar_pkg::OP_SUB, -32768, -1, 32767, -1);
        send_item(rar_pkg::OP_MUL, 12, 18, 15, 10);
        send_item(rar_pkg::OP_ADD, 1, -32768, 1, 32767);
        send_item(rar_pkg::OP_SUB, -32768, 32767, -32768, 32767);
        wait_drained();

        sent = 0;
        burst_left = 0;
        while (sent < RANDOM_ITEMS) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 12);
                case ($urandom_range(0, 7))
                    0, 1, 2: gap = 0;
                    3, 4, 5: gap = $urandom_range(1, 8);
                    6: gap = $urandom_range(9, 40);
                    default: gap = $urandom_range(41, 150);
                endcase
                idle_for(gap);
            end
            if (sent == 200) begin
                rx_hold_asks <= rx_hold_asks + 1;
            end
            if (sent == 400) begin
                wait_drained();
            end
            send_item(rar_pkg::t_op'($urandom_range(0, 3)), rand_operand(), rand_operand(),
                      rand_operand(), rand_operand());
            sent = sent + 1;
            burst_left = burst_left - 1;
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_cnt == 0) begin
            $display("rational_arith_reduce test passed");
        end else begin
            $display("rational_arith_reduce test failed");
        end
        $finish;
    end

endmodule

// File: files.f
design/rar_pkg.sv
design/rar_mul.sv
design/rar_div.sv
design/rational_arith_reduce.sv
design/rar_checker.sv
verif/rar_checker.sv
verif/tb_top.sv
